@@ src/sms_pkg.sv @@
// ----------------------------------------------------------------------------
// sms_pkg: shared constants, types and helpers
// Sizes, time widths and the controller/datapath command and status words
// of the single machine scheduler.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int MAX_TASKS = 64;
  localparam int TIME_BITS = 16;

  localparam int ID_W   = 8;
  localparam int IN_T_W = 16;
  localparam int OUT_T_W = 23;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  // r, p and q keep only TIME_BITS bits
  localparam logic [IN_T_W-1:0] TIME_MASK =
    (TIME_BITS >= IN_T_W) ? {IN_T_W{1'b1}} : IN_T_W'((64'd1 << TIME_BITS) - 64'd1);

  localparam logic [OUT_T_W-1:0] OUT_T_MAX = {OUT_T_W{1'b1}};

  // one stored entry: id, r, p, q
  localparam int ENTRY_W = ID_W + 3 * IN_T_W;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [IN_T_W-1:0] rel;
    logic [IN_T_W-1:0] proc;
    logic [IN_T_W-1:0] tail;
  } entry_t;

  typedef struct packed {
    logic store;       // write accepted word into the store
    logic scan_init;   // restart scan, drop candidates
    logic scan_issue;  // read next entry
    logic take_time;   // commit chosen task, advance machine time
    logic emit;        // load the result register
  } cmd_t;

  typedef struct packed {
    logic scan_last;   // entry being read is the last loaded one
    logic last_task;   // next result closes the schedule
    logic out_free;    // result register can take a word this cycle
  } status_t;

  function automatic logic [OUT_T_W-1:0] sat_time(input logic [OUT_T_W:0] v);
    return v[OUT_T_W] ? OUT_T_MAX : v[OUT_T_W-1:0];
  endfunction

endpackage

@@ src/sms_if.sv @@
// ----------------------------------------------------------------------------
// sms_if: task and result channels
// Valid/ready channels carrying one task word in and one result word out.
// ----------------------------------------------------------------------------
interface sms_task_if;
  import sms_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   task_id;
  logic [IN_T_W-1:0] release_time;
  logic [IN_T_W-1:0] processing_time;
  logic [IN_T_W-1:0] tail_time;
  logic              final_task;

  modport source (
    output valid, task_id, release_time, processing_time, tail_time, final_task,
    input  ready
  );
  modport sink (
    input  valid, task_id, release_time, processing_time, tail_time, final_task,
    output ready
  );
endinterface

interface sms_result_if;
  import sms_pkg::*;

  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    scheduled_id;
  logic [OUT_T_W-1:0] finish_time;
  logic [OUT_T_W-1:0] running_cmax;
  logic               schedule_end;

  modport source (
    output valid, scheduled_id, finish_time, running_cmax, schedule_end,
    input  ready
  );
  modport sink (
    input  valid, scheduled_id, finish_time, running_cmax, schedule_end,
    output ready
  );
endinterface

@@ src/sms_ram.sv @@
// ----------------------------------------------------------------------------
// sms_ram: generic simple dual port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/sms_ctrl.sv @@
// ----------------------------------------------------------------------------
// sms_ctrl: scheduler sequencer
// Loads tasks, then per decision runs a full scan of the store, commits the
// chosen task and hands its result to the output register.
// ----------------------------------------------------------------------------
module sms_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_final,
  output logic             in_ready,
  input  sms_pkg::status_t status,
  output sms_pkg::cmd_t    cmd
);
  import sms_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_INIT  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_TIME  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready  = 1'b1;
        cmd.store = in_valid;
        if (in_valid && in_final) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_TIME;
      end
      S_TIME: begin
        cmd.take_time = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        // hold until the result register frees up
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.last_task ? S_LOAD : S_INIT;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end
endmodule

@@ src/sms_dp.sv @@
// ----------------------------------------------------------------------------
// sms_dp: scheduler datapath
// Task store, scheduled flags, scan compare, machine time, Cmax and the
// result register.
// ----------------------------------------------------------------------------
module sms_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  sms_pkg::cmd_t              cmd,
  output sms_pkg::status_t           status,
  input  logic [sms_pkg::ID_W-1:0]   in_id,
  input  logic [sms_pkg::IN_T_W-1:0] in_rel,
  input  logic [sms_pkg::IN_T_W-1:0] in_proc,
  input  logic [sms_pkg::IN_T_W-1:0] in_tail,
  sms_result_if.source               results
);
  import sms_pkg::*;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     emitted;
  logic [CNT_W-1:0]     scan_idx;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  entry_t               wr_entry;
  entry_t               rd_entry;
  logic [ENTRY_W-1:0]   rd_raw;
  logic                 wr_en;

  // scheduled flag per entry, kept in its own RAM beside the store
  logic                 flag_we;
  logic [IDX_W-1:0]     flag_waddr;
  logic                 rd_flag;

  // best ready task: largest q, lowest index
  logic                 best_valid;
  logic [ID_W-1:0]      best_id;
  logic [IN_T_W-1:0]    best_proc;
  logic [IN_T_W-1:0]    best_tail;
  logic [IDX_W-1:0]     best_idx;
  // earliest pending task: smallest r, then largest q, lowest index
  logic                 min_valid;
  logic [IN_T_W-1:0]    min_rel;
  logic [ID_W-1:0]      min_id;
  logic [IN_T_W-1:0]    min_proc;
  logic [IN_T_W-1:0]    min_tail;
  logic [IDX_W-1:0]     min_idx;

  logic [OUT_T_W-1:0]   mtime;
  logic [OUT_T_W-1:0]   cmax;
  logic [ID_W-1:0]      sel_id;
  logic [IN_T_W-1:0]    sel_tail;
  logic [IDX_W-1:0]     sel_idx;

  logic [OUT_T_W-1:0]   time_base;
  logic [IN_T_W-1:0]    time_proc;
  logic [OUT_T_W-1:0]   done;
  logic                 rd_pending;
  logic                 rd_ready;
  logic                 out_valid;

  assign wr_en    = cmd.store && (count < CNT_W'(MAX_TASKS));
  assign wr_entry = '{id: in_id, rel: in_rel & TIME_MASK, proc: in_proc & TIME_MASK,
                      tail: in_tail & TIME_MASK};

  sms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rd_raw)
  );

  // clear the flag when a task is loaded, set it when the task is emitted
  assign flag_we    = wr_en || cmd.emit;
  assign flag_waddr = cmd.emit ? sel_idx : count[IDX_W-1:0];

  sms_ram #(
    .WIDTH (1),
    .DEPTH (MAX_TASKS)
  ) u_flags (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (cmd.emit),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rd_flag)
  );

  assign rd_entry   = entry_t'(rd_raw);
  assign rd_pending = rd_valid && !rd_flag;
  assign rd_ready   = {{(OUT_T_W-IN_T_W){1'b0}}, rd_entry.rel} <= mtime;

  assign status.scan_last = (scan_idx + CNT_W'(1)) == count;
  assign status.last_task = (emitted + CNT_W'(1)) == count;
  assign status.out_free  = !out_valid || results.ready;

  assign time_base = best_valid ? mtime : {{(OUT_T_W-IN_T_W){1'b0}}, min_rel};
  assign time_proc = best_valid ? best_proc : min_proc;
  assign done      = sat_time({1'b0, mtime} + (OUT_T_W+1)'(sel_tail));

  // store fill and scan sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      scan_idx <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        count <= count + CNT_W'(1);
      end else if (cmd.emit && status.last_task) begin
        count <= '0;
      end
      if (cmd.scan_init) begin
        scan_idx <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      rd_valid <= cmd.scan_issue;
    end
    rd_idx <= scan_idx[IDX_W-1:0];
  end

  // candidate tracking during the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      min_valid  <= 1'b0;
    end else if (cmd.scan_init) begin
      best_valid <= 1'b0;
      min_valid  <= 1'b0;
    end else if (rd_pending) begin
      if (rd_ready && (!best_valid || rd_entry.tail > best_tail)) begin
        best_valid <= 1'b1;
      end
      if (!min_valid || rd_entry.rel < min_rel) begin
        min_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      if (rd_ready && (!best_valid || rd_entry.tail > best_tail)) begin
        best_id   <= rd_entry.id;
        best_proc <= rd_entry.proc;
        best_tail <= rd_entry.tail;
        best_idx  <= rd_idx;
      end
      if (!min_valid || rd_entry.rel < min_rel ||
          (rd_entry.rel == min_rel && rd_entry.tail > min_tail)) begin
        min_rel  <= rd_entry.rel;
        min_id   <= rd_entry.id;
        min_proc <= rd_entry.proc;
        min_tail <= rd_entry.tail;
        min_idx  <= rd_idx;
      end
    end
    if (cmd.take_time) begin
      sel_id   <= best_valid ? best_id : min_id;
      sel_tail <= best_valid ? best_tail : min_tail;
      sel_idx  <= best_valid ? best_idx : min_idx;
    end
  end

  // machine time and Cmax; clear everything after the last result
  always_ff @(posedge clk) begin
    if (rst) begin
      mtime   <= '0;
      cmax    <= '0;
      emitted <= '0;
    end else if (cmd.take_time) begin
      mtime <= sat_time({1'b0, time_base} + (OUT_T_W+1)'(time_proc));
    end else if (cmd.emit) begin
      if (status.last_task) begin
        mtime   <= '0;
        cmax    <= '0;
        emitted <= '0;
      end else begin
        cmax    <= (done > cmax) ? done : cmax;
        emitted <= emitted + CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      results.scheduled_id <= sel_id;
      results.finish_time  <= mtime;
      results.running_cmax <= (done > cmax) ? done : cmax;
      results.schedule_end <= status.last_task;
    end
  end

  assign results.valid = out_valid;

  // never overwrite a word that has not been taken
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result register overwritten");

  // no more results than stored tasks
  a_emit_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (emitted < count))
    else $error("more results than stored tasks");

  // the last result empties the store
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last_task) |=> (count == '0 && emitted == '0))
    else $error("store not cleared after schedule end");

  // Cmax covers the finish time of every emitted task
  a_cmax_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> results.running_cmax >= results.finish_time)
    else $error("running Cmax below finish time");

  // a commit always has a candidate
  a_take_has_cand: assert property (@(posedge clk) disable iff (rst)
    cmd.take_time |-> (best_valid || min_valid))
    else $error("commit without candidate");
endmodule

@@ src/schrage_single_machine_scheduler.sv @@
// ----------------------------------------------------------------------------
// schrage_single_machine_scheduler: Schrage rule scheduler for 1|r,q|Cmax
// Loads a task set, then emits one result word per task in schedule order.
// ----------------------------------------------------------------------------
// Usage:
//   tasks   - valid/ready sink; one task word (id, r, p, q, final_task) is
//             taken per cycle while loading. Up to MAX_TASKS words are kept;
//             further words are dropped. final_task starts scheduling.
//   results - valid/ready source; one word per stored task, in schedule
//             order, schedule_end set on the last (running_cmax is Cmax).
// Timing:
//   Each decision sweeps the whole store through its single read port
//   before it commits a task and emits its result. tasks.ready is low from
//   the final task to the last result. After the last result the store is
//   empty and loading resumes at once.
// Reset: empties the store and returns to loading; no word is pending.
// Stall: a result not taken is held in the output register; the next scan
//   runs on, commits its task and then waits until the register frees up.
// ----------------------------------------------------------------------------
module schrage_single_machine_scheduler (
  input logic          clk,
  input logic          rst,
  sms_task_if.sink     tasks,
  sms_result_if.source results
);
  import sms_pkg::*;

  cmd_t    cmd;
  status_t status;

  sms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tasks.valid),
    .in_final (tasks.final_task),
    .in_ready (tasks.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sms_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .in_id   (tasks.task_id),
    .in_rel  (tasks.release_time),
    .in_proc (tasks.processing_time),
    .in_tail (tasks.tail_time),
    .results (results)
  );
endmodule

@@ test/schrage_single_machine_scheduler_test.sv @@
// ----------------------------------------------------------------------------
// schrage_single_machine_scheduler_test: self-checking bench for the scheduler
// Sends task sets over the task channel and checks every result word
// against a behavioral Schrage predictor or a hand-written result. A directed
// table covers the field extremes, tie-breaks and idle jumps. Random sets
// follow, including one that overflows the store. The sender idles in bursts
// and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module schrage_single_machine_scheduler_test;
  import sms_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RAND_WORDS   = 190;
  localparam int DIR_ROWS     = 18;
  localparam int MAX_REPORTS  = 20;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [IN_T_W-1:0] rel;
    logic [IN_T_W-1:0] proc;
    logic [IN_T_W-1:0] tail;
    logic              fin;
  } task_word_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [OUT_T_W-1:0] finish;
    logic [OUT_T_W-1:0] cmax;
    logic               last;
  } sched_word_t;

  typedef struct packed {
    task_word_t  w;
    logic        typed;
    sched_word_t want;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_LONG} rx_mode_t;

  // the first four single-task sets carry their result inline; the rest go to the predictor
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{8'hA5, 16'd0,     16'd0,     16'd0,     1'b1}, 1'b1,
      '{8'hA5, 23'd0,      23'd0,      1'b1}},
    '{'{8'hFF, 16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1}, 1'b1,
      '{8'hFF, 23'd131070, 23'd196605, 1'b1}},
    '{'{8'h00, 16'd0,     16'd7,     16'd0,     1'b1}, 1'b1,
      '{8'h00, 23'd7,      23'd7,      1'b1}},
    '{'{8'h5A, 16'h5555,  16'hAAAA,  16'h5555,  1'b1}, 1'b1,
      '{8'h5A, 23'd65535,  23'd87380,  1'b1}},
    // equal tails at time zero: lowest load index first
    '{'{8'h10, 16'd0,     16'd4,     16'd9,     1'b0}, 1'b0, '0},
    '{'{8'h11, 16'd0,     16'd3,     16'd9,     1'b0}, 1'b0, '0},
    '{'{8'h12, 16'd0,     16'd2,     16'd20,    1'b1}, 1'b0, '0},
    // unsorted releases, nothing ready at zero
    '{'{8'h20, 16'd50,    16'd5,     16'd1,     1'b0}, 1'b0, '0},
    '{'{8'h21, 16'd10,    16'd5,     16'd2,     1'b0}, 1'b0, '0},
    '{'{8'h22, 16'd30,    16'd1,     16'd8,     1'b1}, 1'b0, '0},
    // zero processing times and a late task with the largest tail
    '{'{8'h30, 16'd0,     16'd10,    16'd1,     1'b0}, 1'b0, '0},
    '{'{8'h31, 16'd2,     16'd0,     16'd100,   1'b0}, 1'b0, '0},
    '{'{8'h32, 16'd0,     16'd0,     16'd0,     1'b0}, 1'b0, '0},
    '{'{8'h33, 16'd100,   16'd3,     16'hFFFF,  1'b1}, 1'b0, '0},
    // identical tasks
    '{'{8'h40, 16'd5,     16'd5,     16'd5,     1'b0}, 1'b0, '0},
    '{'{8'h41, 16'd5,     16'd5,     16'd5,     1'b0}, 1'b0, '0},
    '{'{8'h42, 16'd5,     16'd5,     16'd5,     1'b1}, 1'b0, '0},
    '{'{8'hC3, 16'hAAAA,  16'h5555,  16'hAAAA,  1'b1}, 1'b0, '0}
  };

  logic clk;
  logic rst;

  sms_task_if   tk ();
  sms_result_if rs ();

  schrage_single_machine_scheduler u_dut (
    .clk     (clk),
    .rst     (rst),
    .tasks   (tk),
    .results (rs)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stim_row_t   stim_q [$];
  sched_word_t sched_q [$];

  // predictor copy of the task store
  logic [ID_W-1:0]   pend_id   [MAX_TASKS];
  logic [IN_T_W-1:0] pend_rel  [MAX_TASKS];
  logic [IN_T_W-1:0] pend_proc [MAX_TASKS];
  logic [IN_T_W-1:0] pend_tail [MAX_TASKS];
  bit                pend_done [MAX_TASKS];
  int                pend_cnt = 0;

  int send_idx     = 0;
  int acc_idx      = 0;
  int err_cnt      = 0;
  int checked_cnt  = 0;
  int sched_cnt    = 0;
  int biggest_set  = 0;
  int cycle_cnt    = 0;

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (err_cnt < MAX_REPORTS)
      $display("MISMATCH %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  function automatic int best_ready(input logic [31:0] now);
    int pick;
    pick = -1;
    for (int i = 0; i < pend_cnt; i++) begin
      if (!pend_done[i] && pend_rel[i] <= now)
        if (pick < 0 || pend_tail[i] > pend_tail[pick]) pick = i;
    end
    return pick;
  endfunction

  // Schrage's rule over the stored set; queues one result word per task
  task automatic schedule_set();
    logic [31:0] now;
    logic [31:0] best;
    logic [31:0] done;
    logic [31:0] next;
    int          pick;
    sched_word_t s;
    now  = 0;
    best = 0;
    for (int i = 0; i < MAX_TASKS; i++) pend_done[i] = 1'b0;
    for (int k = 0; k < pend_cnt; k++) begin
      pick = best_ready(now);
      if (pick < 0) begin
        // jump to the earliest pending release
        next = 32'hFFFF_FFFF;
        for (int j = 0; j < pend_cnt; j++)
          if (!pend_done[j] && pend_rel[j] < next) next = pend_rel[j];
        now  = next;
        pick = best_ready(now);
      end
      pend_done[pick] = 1'b1;
      now = now + pend_proc[pick];
      if (now > OUT_T_MAX) now = OUT_T_MAX;
      done = now + pend_tail[pick];
      if (done > OUT_T_MAX) done = OUT_T_MAX;
      if (done > best) best = done;
      s.id     = pend_id[pick];
      s.finish = now[OUT_T_W-1:0];
      s.cmax   = best[OUT_T_W-1:0];
      s.last   = (k + 1 == pend_cnt);
      sched_q  = {sched_q, s};
    end
    if (pend_cnt > biggest_set) biggest_set = pend_cnt;
    pend_cnt = 0;
  endtask

  task automatic load_task(input task_word_t w);
    if (pend_cnt < MAX_TASKS) begin
      pend_id[pend_cnt]   = w.id;
      pend_rel[pend_cnt]  = w.rel & TIME_MASK;
      pend_proc[pend_cnt] = w.proc & TIME_MASK;
      pend_tail[pend_cnt] = w.tail & TIME_MASK;
      pend_cnt++;
    end
    if (w.fin) begin
      schedule_set();
      sched_cnt++;
    end
  endtask

  function automatic int pick_spread();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 15;
      2:       return 400;
      default: return 65535;
    endcase
  endfunction

  function automatic stim_row_t rand_row(input int sr, input int sp, input int sq,
                                         input bit fin);
    stim_row_t row;
    row        = '0;
    row.w.id   = ID_W'($urandom);
    row.w.rel  = IN_T_W'($urandom_range(0, sr));
    row.w.proc = IN_T_W'($urandom_range(0, sp));
    row.w.tail = IN_T_W'($urandom_range(0, sq));
    row.w.fin  = fin;
    return row;
  endfunction

  // task sender: bursts of words with random gaps
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk) begin : task_send
    if (rst) begin
      tk.valid <= 1'b0;
    end else begin
      if (tk.valid && tk.ready) begin
        send_idx++;
        burst_left--;
        if (burst_left <= 0) begin
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 40) :
                                                     $urandom_range(1, 10);
        end
      end
      // hold a word that has not been taken
      if (!(tk.valid && !tk.ready)) begin
        if (gap_left > 0 || send_idx >= stim_q.size()) begin
          if (gap_left > 0) gap_left--;
          tk.valid <= 1'b0;
        end else begin
          tk.valid           <= 1'b1;
          tk.task_id         <= stim_q[send_idx].w.id;
          tk.release_time    <= stim_q[send_idx].w.rel;
          tk.processing_time <= stim_q[send_idx].w.proc;
          tk.tail_time       <= stim_q[send_idx].w.tail;
          tk.final_task      <= stim_q[send_idx].w.fin;
        end
      end
    end
  end

  // result receiver: stall pattern changes mode every so often
  rx_mode_t rx_mode    = RX_OPEN;
  int       phase_left = 0;
  int       stall_left = 0;

  always @(posedge clk) begin : result_recv
    if (rst) begin
      rs.ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 150);
      end else begin
        phase_left--;
      end
      case (rx_mode)
        RX_OPEN:   rs.ready <= 1'b1;
        RX_COIN:   rs.ready <= 1'($urandom_range(0, 1));
        RX_EVERY4: rs.ready <= (cycle_cnt % 4 == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rs.ready <= 1'b0;
          end else begin
            stall_left = $urandom_range(0, 20);
            rs.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin : watch
    task_word_t  w;
    sched_word_t got;
    sched_word_t want;
    if (!rst) begin
      if (tk.valid && tk.ready) begin
        w.id   = tk.task_id;
        w.rel  = tk.release_time;
        w.proc = tk.processing_time;
        w.tail = tk.tail_time;
        w.fin  = tk.final_task;
        load_task(w);
        // swap in the hand-written result of a single-task set
        if (stim_q[acc_idx].typed) begin
          sched_q[sched_q.size() - 1] = stim_q[acc_idx].want;
        end
        acc_idx++;
      end
      if (rs.valid && rs.ready) begin
        got.id     = rs.scheduled_id;
        got.finish = rs.finish_time;
        got.cmax   = rs.running_cmax;
        got.last   = rs.schedule_end;
        if (sched_q.size() == 0) begin
          flag_mismatch("unexpected result word, id", got.id, 0);
        end else begin
          want = sched_q.pop_front();
          checked_cnt++;
          if (got.id !== want.id)         flag_mismatch("scheduled_id", got.id, want.id);
          if (got.finish !== want.finish) flag_mismatch("finish_time", got.finish, want.finish);
          if (got.cmax !== want.cmax)     flag_mismatch("running_cmax", got.cmax, want.cmax);
          if (got.last !== want.last)     flag_mismatch("schedule_end", got.last, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, sched_q.size());
      $display("schrage_single_machine_scheduler verification failed");
      $finish;
    end
  end

  initial begin : main
    int n;
    int extra;
    int stored;
    int sr;
    int sp;
    int sq;
    rst                = 1'b1;
    tk.valid           = 1'b0;
    tk.task_id         = '0;
    tk.release_time    = '0;
    tk.processing_time = '0;
    tk.tail_time       = '0;
    tk.final_task      = 1'b0;
    rs.ready           = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) stim_q = {stim_q, DIR_TABLE[i]};

    // overfill the store: the extra words are dropped, the last one still
    // carries final_task
    extra = $urandom_range(1, 3);
    sr = pick_spread();
    sp = pick_spread();
    sq = pick_spread();
    for (int k = 0; k < MAX_TASKS + extra; k++)
      stim_q = {stim_q, rand_row(sr, sp, sq, k == MAX_TASKS + extra - 1)};
    stored = MAX_TASKS;

    while (stored < RAND_WORDS) begin
      n  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      sr = pick_spread();
      sp = pick_spread();
      sq = pick_spread();
      for (int k = 0; k < n; k++) stim_q = {stim_q, rand_row(sr, sp, sq, k == n - 1)};
      stored += n;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (send_idx < stim_q.size()) @(posedge clk);
    while (sched_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d task words in %0d schedules (largest set %0d tasks)",
             stim_q.size(), sched_cnt, biggest_set);
    $display("checked %0d result words, %0d mismatches", checked_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("schrage_single_machine_scheduler verification clean");
    end else begin
      $display("schrage_single_machine_scheduler verification failed");
    end
    $finish;
  end

endmodule
